/* hdl/lpr_pkg.sv */
package lpr_pkg;

	localparam int FIELD_W    = 6;
	localparam int COLOR_W    = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W  = OUT_DATA_W - 2 * FIELD_W - COLOR_W;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

/* hdl/lpr_datapath.sv */
module lpr_datapath #(
	parameter int COORD_BITS = 6
) (
	input  logic                            clk,
	input  lpr_pkg::cmd_t                   cmd,
	output lpr_pkg::sts_t                   sts,
	input  logic [lpr_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic [lpr_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);
	import lpr_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int E_W = COORD_BITS + 3;

	logic [C-1:0] ax, ay, bx, by, dx, dy;
	logic [C-1:0] pa, qa, pb, qb, p0, q0, p1, q1;
	logic         y_major, swap;

	logic [C-1:0]       p_q, q_q, pend_q, major_q, minor_q;
	logic signed [E_W-1:0] e_q, e_sum, e2;
	logic               dir_q, ymaj_q;
	logic [COLOR_W-1:0] color_q;
	logic               adv;

	logic [FIELD_W-1:0] out_x_q, out_y_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_last_q;

	// coordinates are masked to the low COORD_BITS of each field
	assign ax = s_tdata[0*FIELD_W +: C];
	assign ay = s_tdata[1*FIELD_W +: C];
	assign bx = s_tdata[2*FIELD_W +: C];
	assign by = s_tdata[3*FIELD_W +: C];

	assign dx      = (bx > ax) ? bx - ax : ax - bx;
	assign dy      = (by > ay) ? by - ay : ay - by;
	assign y_major = dx < dy;

	assign pa   = y_major ? ay : ax;
	assign qa   = y_major ? ax : ay;
	assign pb   = y_major ? by : bx;
	assign qb   = y_major ? bx : by;
	assign swap = pb < pa;
	assign p0   = swap ? pb : pa;
	assign q0   = swap ? qb : qa;
	assign p1   = swap ? pa : pb;
	assign q1   = swap ? qa : qb;

	// error term for the next major step
	assign e_sum = e_q + $signed({3'b000, minor_q});
	assign e2    = $signed({e_sum[E_W-2:0], 1'b0});
	assign adv   = e2 > $signed({3'b000, major_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q     <= p0;
			q_q     <= q0;
			pend_q  <= p1;
			major_q <= p1 - p0;
			minor_q <= (q1 > q0) ? q1 - q0 : q0 - q1;
			dir_q   <= q1 > q0;
			ymaj_q  <= y_major;
			color_q <= s_tdata[4*FIELD_W +: COLOR_W];
			e_q     <= '0;
		end else if (cmd.step) begin
			p_q <= p_q + 1'b1;
			if (adv) begin
				q_q <= dir_q ? q_q + 1'b1 : q_q - 1'b1;
				e_q <= e_sum - $signed({3'b000, major_q});
			end else begin
				e_q <= e_sum;
			end
		end
	end

	assign sts.last = p_q == pend_q;

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_x_q     <= FIELD_W'(ymaj_q ? q_q : p_q);
			out_y_q     <= FIELD_W'(ymaj_q ? p_q : q_q);
			out_color_q <= color_q;
			out_last_q  <= sts.last;
		end
	end

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_color_q, out_y_q, out_x_q};
	assign m_tlast = out_last_q;

endmodule

/* hdl/lpr_controller.sv */
module lpr_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  lpr_pkg::sts_t sts,
	output lpr_pkg::cmd_t cmd
);
	import lpr_pkg::*;

	state_t state_q, state_d;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.step && sts.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_RUN: begin
				cmd.step = !out_vld_q || m_tready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign m_tvalid = out_vld_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && out_vld_q && !m_tready))
		else $error("output register overwritten while stalled");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE && !cmd.step)
		else $error("load outside idle");

	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN)
		else $error("no run after load");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.last |=> state_q == ST_IDLE && m_tvalid)
		else $error("line did not finish after last pixel");

endmodule

/* hdl/line_pixel_rasterizer_unit.sv */
// channel  dir  tdata fields (low bit up)                           tlast
// s        in   start_x, start_y, end_x, end_y, pixel_color         -
// m        out  pixel_x, pixel_y, out_color, zero pad               last_pixel
//
// After the line transfer the step loop registers one pixel per cycle unless m stalls.
// The input is held off (s_tready low) while the step loop runs over a line.
// The next line is taken once the last pixel has left the generator.
// Reset clears the controller state and output valid; payload registers are not reset.
// A stall on m holds the output register and pauses the step loop.
module line_pixel_rasterizer_unit #(
	parameter int COORD_BITS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lpr_pkg::IN_DATA_W-1:0]   s_tdata,  // start_x, start_y, end_x, end_y, pixel_color
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lpr_pkg::OUT_DATA_W-1:0]  m_tdata,  // pixel_x, pixel_y, out_color, pad
	output logic                            m_tlast
);
	import lpr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lpr_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
